// ===== sv/bssc_pkg.sv =====
// Shared types and constants for the barometric sequencer/compensation block.
// No dependencies.
`default_nettype none

package bssc_pkg;

    localparam int BSSC_RAW_W      = 24;
    localparam int BSSC_COEFF_W    = 16;
    localparam int BSSC_IDX_W      = 3;
    localparam int BSSC_TEMP_W     = 15;
    localparam int BSSC_PRES_W     = 18;
    localparam int BSSC_QUEUE_DEPTH = 2;

    localparam int TEMP_MIN    = -4000;
    localparam int TEMP_MAX    = 8500;
    localparam int TEMP_OFFSET = 2000;
    localparam int PRES_MAX    = 150000;

    localparam logic [BSSC_IDX_W-1:0] REG_SENS     = 3'd0;
    localparam logic [BSSC_IDX_W-1:0] REG_OFF      = 3'd1;
    localparam logic [BSSC_IDX_W-1:0] REG_TCS      = 3'd2;
    localparam logic [BSSC_IDX_W-1:0] REG_TCO      = 3'd3;
    localparam logic [BSSC_IDX_W-1:0] REG_TREF     = 3'd4;
    localparam logic [BSSC_IDX_W-1:0] REG_TEMPSENS = 3'd5;

    // one queued request: snapshot of the raw pair after this reading is stored
    typedef struct packed {
        logic [BSSC_RAW_W-1:0] raw_temperature;
        logic [BSSC_RAW_W-1:0] raw_pressure;
        logic                  was_temperature;
    } bssc_job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_FIN
    } bssc_state_t;

endpackage

`default_nettype wire

// ===== sv/baro_sensor_sequencer_compensation.sv =====
// Barometric sensor sequencer with second-order compensation, top level.
// Depends on bssc_pkg, bssc_front, bssc_fifo, bssc_back.
// Usage:
//   s_valid/s_ready/s_raw_reading carry one 24-bit conversion result per
//   request. Readings alternate temperature, pressure, starting with
//   temperature after reset. Each request gives one result on
//   m_valid/m_ready: compensated temperature (0.01 C), pressure (Pa), the
//   stage the reading was stored in and the conversion to start next.
//   Calibration words are written through cfg_we/cfg_index/cfg_wdata while
//   the block is idle; indexes beyond the six words are ignored.
// Timing:
//   The back end takes one request at a time and steps it through the
//   sequence of multiplies on its single shared 26x26 multiplier; it takes
//   the next request only once the result is loaded into the output register.
//   A two-entry queue lets the front end take readings while a result
//   waits; s_ready drops only when the queue is full.
// Reset:
//   aresetn (synchronous, active low) clears the calibration words, the
//   stage and both raw readings. A stalled receiver holds the result
//   stable and the back end waits in its final step.
`default_nettype none

module baro_sensor_sequencer_compensation
    import bssc_pkg::*;
#(
    parameter int QUEUE_DEPTH = BSSC_QUEUE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [BSSC_IDX_W-1:0]    cfg_index,
    input  wire logic [BSSC_COEFF_W-1:0]  cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [BSSC_RAW_W-1:0]    s_raw_reading,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [BSSC_TEMP_W-1:0] m_temperature_centi,
    output logic [BSSC_PRES_W-1:0]        m_pressure_pa,
    output logic                          m_was_temperature,
    output logic                          m_next_conversion
);

    logic      q_push, q_full, q_pop, q_not_empty;
    bssc_job_t push_job, pop_job;

    bssc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_reading (s_raw_reading),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    bssc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    bssc_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .q_not_empty         (q_not_empty),
        .q_job               (pop_job),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_pa       (m_pressure_pa),
        .m_was_temperature   (m_was_temperature),
        .m_next_conversion   (m_next_conversion)
    );

endmodule

`default_nettype wire

// ===== sv/bssc_front.sv =====
// Front end: accepts readings, tracks the temperature/pressure stage and raw pair.
// Depends on bssc_pkg.
`default_nettype none

module bssc_front
    import bssc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [BSSC_RAW_W-1:0] s_raw_reading,
    input  wire logic                  q_full,
    output logic                       q_push,
    output bssc_job_t                  q_job
);

    logic                  stage_reg, stage_next;
    logic [BSSC_RAW_W-1:0] raw_t_reg, raw_t_next;
    logic [BSSC_RAW_W-1:0] raw_p_reg, raw_p_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        stage_next = stage_reg;
        raw_t_next = raw_t_reg;
        raw_p_next = raw_p_reg;
        if (q_push) begin
            stage_next = !stage_reg;
            if (!stage_reg) begin
                raw_t_next = s_raw_reading;
            end else begin
                raw_p_next = s_raw_reading;
            end
        end
    end

    assign q_job.raw_temperature = raw_t_next;
    assign q_job.raw_pressure    = raw_p_next;
    assign q_job.was_temperature = !stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            raw_t_reg <= '0;
            raw_p_reg <= '0;
        end else begin
            stage_reg <= stage_next;
            raw_t_reg <= raw_t_next;
            raw_p_reg <= raw_p_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bssc_fifo.sv =====
// Short request queue between front and back end, register based.
// Depends on bssc_pkg.
`default_nettype none

module bssc_fifo
    import bssc_pkg::*;
#(
    parameter int DEPTH = BSSC_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire bssc_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output bssc_job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bssc_job_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bssc_back.sv =====
// Back end: calibration registers, sequenced compensation on one shared
// 26x26 multiplier, saturation and the output register. Depends on bssc_pkg.
`default_nettype none

module bssc_back
    import bssc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [BSSC_IDX_W-1:0]   cfg_index,
    input  wire logic [BSSC_COEFF_W-1:0] cfg_wdata,
    input  wire logic                    q_not_empty,
    input  wire bssc_job_t               q_job,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [BSSC_TEMP_W-1:0] m_temperature_centi,
    output logic [BSSC_PRES_W-1:0]       m_pressure_pa,
    output logic                         m_was_temperature,
    output logic                         m_next_conversion
);

    localparam int MUL_W = 26;
    localparam int PRD_W = 2 * MUL_W;

    logic [BSSC_COEFF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    bssc_state_t state_reg, state_next;

    logic [BSSC_RAW_W-1:0]    raw_t_reg, raw_p_reg;
    logic                     was_t_reg;
    logic signed [24:0]       dt_reg;
    logic signed [18:0]       t_reg;
    logic signed [39:0]       off_reg;
    logic signed [39:0]       sens_reg;
    logic signed [PRD_W-1:0]  aux_reg;
    logic signed [39:0]       aux5_reg;
    logic signed [PRD_W-1:0]  acc_reg;
    logic signed [63:0]       full_reg;
    logic signed [43:0]       diff_reg;
    logic signed [PRD_W-1:0]  prod_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PRD_W-1:0]  mul_p;
    logic                     out_load;

    logic                            m_valid_reg;
    logic signed [BSSC_TEMP_W-1:0]   temp_out_reg;
    logic [BSSC_PRES_W-1:0]          pres_out_reg;
    logic                            was_out_reg;

    logic signed [18:0] temp_full;
    logic signed [28:0] pres_full;
    logic signed [BSSC_TEMP_W-1:0] temp_sat;
    logic [BSSC_PRES_W-1:0]        pres_sat;

    assign mul_p = mul_a * mul_b;

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SENS:     c1_reg <= cfg_wdata;
                REG_OFF:      c2_reg <= cfg_wdata;
                REG_TCS:      c3_reg <= cfg_wdata;
                REG_TCO:      c4_reg <= cfg_wdata;
                REG_TREF:     c5_reg <= cfg_wdata;
                REG_TEMPSENS: c6_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_not_empty) state_next = ST_DT;
            ST_DT:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = ST_M7;
            ST_M7:   state_next = ST_P1;
            ST_P1:   state_next = ST_P2;
            ST_P2:   state_next = ST_P3;
            ST_P3:   state_next = ST_P4;
            ST_P4:   state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        mul_a    = MUL_W'(dt_reg);
        mul_b    = $signed({10'b0, c6_reg});
        unique case (state_reg)
            ST_IDLE: q_pop = q_not_empty;
            ST_M1: begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed({10'b0, c6_reg});
            end
            ST_M2: begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed({10'b0, c4_reg});
            end
            ST_M3: begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed({10'b0, c3_reg});
            end
            ST_M4: begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(t_reg);
            end
            ST_M5: begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'(dt_reg);
            end
            ST_P1: begin
                mul_a = $signed({2'b0, raw_p_reg});
                mul_b = $signed({6'b0, sens_reg[19:0]});
            end
            ST_P2: begin
                mul_a = $signed({2'b0, raw_p_reg});
                mul_b = MUL_W'($signed(sens_reg[39:20]));
            end
            ST_FIN:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            ST_IDLE: begin
                raw_t_reg <= q_job.raw_temperature;
                raw_p_reg <= q_job.raw_pressure;
                was_t_reg <= q_job.was_temperature;
            end
            ST_DT:
                dt_reg <= $signed({1'b0, raw_t_reg}) - $signed({1'b0, c5_reg, 8'h00});
            ST_M2:
                t_reg <= 19'(prod_reg >>> 23);
            ST_M3:
                off_reg <= $signed({8'b0, c2_reg, 16'h0000}) + 40'(prod_reg >>> 7);
            ST_M4:
                sens_reg <= $signed({9'b0, c1_reg, 15'h0000}) + 40'(prod_reg >>> 8);
            ST_M5:
                aux_reg <= prod_reg;
            ST_M6: begin
                aux5_reg <= 40'(aux_reg) + (40'(aux_reg) <<< 2);
                if (t_reg < 0) begin
                    t_reg <= t_reg - 19'(prod_reg >>> 31);
                end
            end
            ST_M7: begin
                if (t_reg < 0) begin
                    off_reg  <= off_reg - (aux5_reg >>> 1);
                    sens_reg <= sens_reg - (aux5_reg >>> 2);
                end
            end
            ST_P2:
                acc_reg <= prod_reg;
            ST_P3:
                full_reg <= (64'(prod_reg) <<< 20) + 64'(acc_reg);
            ST_P4:
                diff_reg <= 44'(full_reg >>> 21) - 44'(off_reg);
            default: ;
        endcase
    end

    // saturation
    always_comb begin
        temp_full = t_reg + 19'(TEMP_OFFSET);
        pres_full = 29'(diff_reg >>> 15);
        if (temp_full < TEMP_MIN) begin
            temp_sat = BSSC_TEMP_W'(TEMP_MIN);
        end else if (temp_full > TEMP_MAX) begin
            temp_sat = BSSC_TEMP_W'(TEMP_MAX);
        end else begin
            temp_sat = BSSC_TEMP_W'(temp_full);
        end
        if (pres_full < 0) begin
            pres_sat = '0;
        end else if (pres_full > PRES_MAX) begin
            pres_sat = BSSC_PRES_W'(PRES_MAX);
        end else begin
            pres_sat = BSSC_PRES_W'(pres_full);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            temp_out_reg <= temp_sat;
            pres_out_reg <= pres_sat;
            was_out_reg  <= was_t_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = temp_out_reg;
    assign m_pressure_pa       = pres_out_reg;
    assign m_was_temperature   = was_out_reg;
    assign m_next_conversion   = !was_out_reg;

endmodule

`default_nettype wire
